// ----- rtl/core/vertex_transform_4x4_core_defines.svh -----
`ifndef VERTEX_TRANSFORM_4X4_CORE_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante; off while in reset.
`define VT44_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vt44: same-cycle check failed");

// Check that cons holds in the cycle after ante; off while in reset.
`define VT44_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vt44: next-cycle check failed");

`endif

// ----- rtl/core/vt44_pkg.sv -----
package vt44_pkg;

  localparam int NUM_COMP  = 4;
  localparam int COMP_W    = 32;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 12;
  localparam int PROD_W    = COMP_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CFG_W     = NUM_COMP * COEF_W;
  localparam int CFG_IDX_W = 2;

  // Q16.16 one, stands in for w on point items
  localparam logic signed [COMP_W-1:0] ONE_Q16 = 32'sd65536;

  // Identity matrix
  localparam logic [CFG_W-1:0] COEF_RST [NUM_COMP] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_X = 2'd0,
    CFG_COEF_Y = 2'd1,
    CFG_COEF_Z = 2'd2,
    CFG_COEF_W = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_POINT  = 1'b0,
    KIND_VECTOR = 1'b1
  } kind_e;

  typedef logic [NUM_COMP-1:0][COMP_W-1:0] vec_t;
  typedef logic [NUM_COMP-1:0][COEF_W-1:0] coef_col_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctrl_t;

  typedef struct packed {
    logic [COMP_W-1:0] value;
    logic              sat;
  } lane_res_t;

endpackage

// ----- rtl/core/vt44_in_if.sv -----
interface vt44_in_if;
  import vt44_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic signed [COMP_W-1:0] in_x;
  logic signed [COMP_W-1:0] in_y;
  logic signed [COMP_W-1:0] in_z;
  logic signed [COMP_W-1:0] in_w;

  modport source (output valid, kind, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, kind, in_x, in_y, in_z, in_w, output ready);
endinterface

// ----- rtl/core/vt44_out_if.sv -----
interface vt44_out_if;
  import vt44_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [COMP_W-1:0] out_x;
  logic signed [COMP_W-1:0] out_y;
  logic signed [COMP_W-1:0] out_z;
  logic signed [COMP_W-1:0] out_w;
  logic              saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

// ----- rtl/core/vt44_lane.sv -----
module vt44_lane (
  input  logic                  clk_i,
  input  vt44_pkg::lane_ctrl_t  ctrl_i,
  input  vt44_pkg::vec_t        vec_i,
  input  vt44_pkg::coef_col_t   coef_i,
  output vt44_pkg::lane_res_t   res_o
);
  import vt44_pkg::*;

  localparam int SH_W = SUM_W - COEF_FRAC;

  logic signed [PROD_W-1:0] prod_d [NUM_COMP];
  logic signed [PROD_W-1:0] prod_q [NUM_COMP];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic        [SH_W-1:0]   sh;
  logic                     ovf;

  // Multiply each input component by its coefficient for this output
  always_comb begin
    for (int c = 0; c < NUM_COMP; c++) begin
      prod_d[c] = PROD_W'($signed(vec_i[c])) * PROD_W'($signed(coef_i[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod) begin
      prod_q <= prod_d;
    end
  end

  // Add the four products at full precision
  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NUM_COMP; c++) begin
      sum_d = sum_d + SUM_W'(prod_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_sum) begin
      sum_q <= sum_d;
    end
  end

  // Drop the fraction bits (floor) and clip to 32 bits
  always_comb begin
    sh  = sum_q[SUM_W-1:COEF_FRAC];
    ovf = !((&sh[SH_W-1:COMP_W-1]) || !(|sh[SH_W-1:COMP_W-1]));
    res_o.sat = ovf;
    if (!ovf) begin
      res_o.value = sh[COMP_W-1:0];
    end else if (sh[SH_W-1]) begin
      res_o.value = {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      res_o.value = {1'b0, {(COMP_W-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/core/vt44_merge.sv -----
module vt44_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  vt44_pkg::lane_res_t  res_i [vt44_pkg::NUM_COMP],
  vt44_out_if.source           out_o
);
  import vt44_pkg::*;

  logic              out_valid_q;
  logic [COMP_W-1:0] val_q [NUM_COMP];
  logic              sat_d;
  logic              sat_q;

  // Take a new result when the output register is empty or being drained
  assign ready_o = !out_valid_q || out_o.ready;

  // Combine the lane clip flags
  always_comb begin
    sat_d = 1'b0;
    for (int k = 0; k < NUM_COMP; k++) begin
      sat_d = sat_d | res_i[k].sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      for (int k = 0; k < NUM_COMP; k++) begin
        val_q[k] <= res_i[k].value;
      end
      sat_q <= sat_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_x     = val_q[0];
  assign out_o.out_y     = val_q[1];
  assign out_o.out_z     = val_q[2];
  assign out_o.out_w     = val_q[3];
  assign out_o.saturated = sat_q;

endmodule

// ----- rtl/core/vertex_transform_4x4_core.sv -----
// Vertex transform: multiplies each vertex (x, y, z, w in signed Q16.16) by a
// 4x4 matrix of signed Q3.12 coefficients held in four 64-bit registers, one
// per input component, identity after reset. A point item (kind 0) uses 1.0
// for w so the translation row is added. Each output is the exact sum of four
// products, floored by 12 bits and clipped to 32 bits; saturated flags any
// clip. One vertex is taken every clock unless the output stalls; a result
// passes through the product register and the sum register of the four
// output lanes, each lane with four 32x16 multipliers, then the output
// register. Write the matrix only while no vertex is in flight.
`include "vertex_transform_4x4_core_defines.svh"

module vertex_transform_4x4_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vt44_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vt44_pkg::CFG_W-1:0]     cfg_wdata_i,
  vt44_in_if.sink                        in_i,
  vt44_out_if.source                     out_o
);
  import vt44_pkg::*;

  logic [CFG_W-1:0] coef_q [NUM_COMP];
  logic             v1_q;
  logic             v2_q;
  logic             s1_ready;
  logic             s2_ready;
  logic             merge_ready;
  lane_ctrl_t       lane_ctrl;
  vec_t             vec;
  coef_col_t        coef_col [NUM_COMP];
  lane_res_t        lane_res [NUM_COMP];

  // Write the matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_COEF_X: coef_q[0] <= cfg_wdata_i;
        CFG_COEF_Y: coef_q[1] <= cfg_wdata_i;
        CFG_COEF_Z: coef_q[2] <= cfg_wdata_i;
        CFG_COEF_W: coef_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage flow: each stage advances when the one after it has room
  assign s2_ready  = !v2_q || merge_ready;
  assign s1_ready  = !v1_q || s2_ready;
  assign in_i.ready = s1_ready;

  assign lane_ctrl.ld_prod = in_i.valid && s1_ready;
  assign lane_ctrl.ld_sum  = v1_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= in_i.valid;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  // Form the input vector, substituting one for w on points
  assign vec[0] = in_i.in_x;
  assign vec[1] = in_i.in_y;
  assign vec[2] = in_i.in_z;
  assign vec[3] = (kind_e'(in_i.kind) == KIND_VECTOR) ? in_i.in_w : ONE_Q16;

  // One lane per output component
  for (genvar k = 0; k < NUM_COMP; k++) begin : g_lane
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
      assign coef_col[k][c] = coef_q[c][k*COEF_W +: COEF_W];
    end

    vt44_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .vec_i  (vec),
      .coef_i (coef_col[k]),
      .res_o  (lane_res[k])
    );
  end

  vt44_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .ready_o (merge_ready),
    .res_i   (lane_res),
    .out_o   (out_o)
  );

  `VT44_ASSERT_NXT(a_in_to_s1, in_i.valid && in_i.ready, v1_q)
  `VT44_ASSERT_NXT(a_s1_hold, v1_q && !s2_ready, v1_q)
  `VT44_ASSERT_NXT(a_s2_hold, v2_q && !merge_ready, v2_q)
  `VT44_ASSERT_NXT(a_s2_to_out, v2_q && merge_ready, out_o.valid)

endmodule
